// ===== src/ctlc_pkg.sv =====
// shared types, codes and reset values for the crossing traffic light controller
// no dependencies; used by the channel interfaces and the top level

package ctlc_pkg;

   localparam int POT_BITS_DEFAULT = 12;

   localparam int DUTY_W    = 16;
   localparam int TICK_W    = 16;
   localparam int CMD_W     = 2;
   localparam int CODE_W    = 3;
   localparam int LIGHT_W   = 3;
   localparam int PHASE_W   = 3;
   localparam int CSR_IDX_W = 3;

   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [CODE_W-1:0]    code_type;
   typedef logic [LIGHT_W-1:0]   light_type;
   typedef logic [DUTY_W-1:0]    duty_type;
   typedef logic [TICK_W-1:0]    tick_type;
   typedef logic [PHASE_W-1:0]   phase_code_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // event kinds
   localparam cmd_type CMD_TICK   = 2'd0;
   localparam cmd_type CMD_BUTTON = 2'd1;
   localparam cmd_type CMD_REMOTE = 2'd2;

   // remote command codes
   localparam code_type RC_TRAIN_ARRIVE = 3'd1;
   localparam code_type RC_MAINT_START  = 3'd2;
   localparam code_type RC_TRAIN_LEAVE  = 3'd3;
   localparam code_type RC_MAINT_END    = 3'd4;

   // rgb lamp codes
   localparam light_type LAMP_OFF    = 3'b000;
   localparam light_type LAMP_GREEN  = 3'b010;
   localparam light_type LAMP_YELLOW = 3'b110;
   localparam light_type LAMP_RED    = 3'b100;
   localparam light_type LAMP_BLUE   = 3'b001;

   // register map
   localparam csr_idx_type CSR_TRAFFIC_TICKS = 3'd0;
   localparam csr_idx_type CSR_YELLOW_TICKS  = 3'd1;
   localparam csr_idx_type CSR_WALK_TICKS    = 3'd2;
   localparam csr_idx_type CSR_GATE_OPEN     = 3'd3;
   localparam csr_idx_type CSR_GATE_CLOSED   = 3'd4;

   localparam tick_type TRAFFIC_TICKS_RESET = 16'd100;
   localparam tick_type YELLOW_TICKS_RESET  = 16'd30;
   localparam tick_type WALK_TICKS_RESET    = 16'd100;
   localparam duty_type GATE_OPEN_RESET     = 16'd52428;
   localparam duty_type GATE_CLOSED_RESET   = 16'd13107;

   // maintenance blink period in ticks
   localparam int BLINK_PERIOD = 5;
   localparam int BLINK_W      = $clog2(BLINK_PERIOD);

endpackage

// ===== src/ctlc_if.sv =====
// valid/ready channel interfaces: request, response and register write
// depends on ctlc_pkg for payload types

interface ctlc_req_if #(parameter int POT_BITS = ctlc_pkg::POT_BITS_DEFAULT);
   logic                 valid;
   logic                 ready;
   ctlc_pkg::cmd_type    cmd;
   ctlc_pkg::code_type   remote_code;
   logic [POT_BITS-1:0]  pot_sample;

   modport source (output valid, cmd, remote_code, pot_sample, input ready);
   modport sink   (input valid, cmd, remote_code, pot_sample, output ready);
endinterface

interface ctlc_rsp_if;
   logic                       valid;
   logic                       ready;
   ctlc_pkg::light_type        light_code;
   logic                       walk_lamp;
   ctlc_pkg::duty_type         gate_duty;
   ctlc_pkg::phase_code_type   phase;

   modport source (output valid, light_code, walk_lamp, gate_duty, phase, input ready);
   modport sink   (input valid, light_code, walk_lamp, gate_duty, phase, output ready);
endinterface

interface ctlc_csr_if;
   logic                    valid;
   logic                    ready;
   ctlc_pkg::csr_idx_type   index;
   ctlc_pkg::duty_type      wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== src/crossing_traffic_light_controller.sv =====
// crossing traffic light controller: phase sequencer, gate duty and response pipeline
// depends on ctlc_pkg and the channel interfaces in ctlc_if.sv
//
// an accepted request is held in stage 1 until the response slot is free or being taken,
//   then moves into the response registers; throughput is one request per cycle while
//   the response is not stalled; stage 1 holds the phase logic and the 16 x POT_BITS
//   duty multiplier, stage 2 the divide by the pot full scale and the gate register
// reset (synchronous, active high): traffic moving, green lamp, gate at the open duty,
//   all flags and the tick count cleared, registers back to their default values

module crossing_traffic_light_controller #(
   parameter int POT_BITS = ctlc_pkg::POT_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   ctlc_req_if.sink      req_bus,
   ctlc_rsp_if.source    rsp_bus,
   ctlc_csr_if.sink      csr_bus
);
   import ctlc_pkg::*;

   // divide by full scale F = 2^POT_BITS - 1: product width, number of shifted terms
   // in the reciprocal series, and the widths of the running sum and the estimate
   localparam int PROD_W = DUTY_W + POT_BITS;
   localparam int NTERMS = (PROD_W + POT_BITS - 1) / POT_BITS;
   localparam int SUM_W  = PROD_W + 2;
   localparam int QE_W   = SUM_W - POT_BITS;
   localparam logic [POT_BITS-1:0] POT_FULL = '1;

   typedef enum logic [PHASE_W-1:0] {
      PH_MOVING  = 3'd0,
      PH_YELLOW  = 3'd1,
      PH_STOPPED = 3'd2,
      PH_WALK    = 3'd3,
      PH_TRAIN   = 3'd4,
      PH_LEAVING = 3'd5,
      PH_MAINT   = 3'd6
   } phase_type;

   // what stage 2 does to the gate register
   typedef enum logic [1:0] {
      GATE_KEEP,
      GATE_LOAD,
      GATE_POT
   } gate_act_type;

   typedef struct packed {
      light_type           light;
      logic                walk;
      phase_type           phase;
      gate_act_type        act;
      duty_type            load_val;
      duty_type            lo;
      logic                up;
      logic [PROD_W-1:0]   prod;
   } stage_type;

   // ---------------------------------------------------------------- registers
   tick_type   traffic_ticks_ff, yellow_ticks_ff, walk_ticks_ff;
   duty_type   gate_open_ff, gate_closed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         traffic_ticks_ff <= TRAFFIC_TICKS_RESET;
         yellow_ticks_ff  <= YELLOW_TICKS_RESET;
         walk_ticks_ff    <= WALK_TICKS_RESET;
         gate_open_ff     <= GATE_OPEN_RESET;
         gate_closed_ff   <= GATE_CLOSED_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_TRAFFIC_TICKS: traffic_ticks_ff <= csr_bus.wdata;
            CSR_YELLOW_TICKS:  yellow_ticks_ff  <= csr_bus.wdata;
            CSR_WALK_TICKS:    walk_ticks_ff    <= csr_bus.wdata;
            CSR_GATE_OPEN:     gate_open_ff     <= csr_bus.wdata;
            CSR_GATE_CLOSED:   gate_closed_ff   <= csr_bus.wdata;
            default: ;
         endcase
      end
   end

   // writes never stall
   assign csr_bus.ready = 1'b1;

   // ---------------------------------------------------------------- state
   phase_type            phase_ff, phase_in;
   tick_type             tick_ff, tick_in;
   logic [BLINK_W-1:0]   blink_cnt_ff, blink_cnt_in;   // tick count mod blink period
   logic                 green_el_ff, green_el_in;
   logic                 yellow_el_ff, yellow_el_in;
   logic                 leave_el_ff, leave_el_in;
   logic                 walk_el_ff, walk_el_in;
   logic                 walk_req_ff, walk_req_in;
   logic                 train_ff, train_in;
   logic                 maint_ff, maint_in;
   logic                 parity_ff, parity_in;
   light_type            light_ff, light_in;
   logic                 walk_lamp_ff, walk_lamp_in;

   // pipeline
   logic                 s1_valid_ff, s1_valid_in;
   stage_type            s1_ff, s1_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   light_type            rsp_light_ff;
   logic                 rsp_walk_ff;
   phase_type            rsp_phase_ff;
   duty_type             gate_ff, gate_in;

   logic                 req_accept;
   logic                 s2_adv;
   logic                 s1_free;

   // combinational helpers for stage 1
   tick_type             tick_inc;
   logic [BLINK_W-1:0]   blink_step;
   logic                 adv;
   gate_act_type         act;
   duty_type             load_val;
   logic                 up;
   duty_type             diff;

   // stage 2 divide
   logic [SUM_W-1:0]     sum;
   logic [QE_W-1:0]      q_est;
   logic [SUM_W-1:0]     rem;
   logic [QE_W-1:0]      quot_full;
   duty_type             quot;

   assign s2_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign s1_free    = !s1_valid_ff || s2_adv;
   assign req_accept = req_bus.valid && s1_free;
   assign req_bus.ready = s1_free;

   // ---------------------------------------------------------------- stage 1: event + phase logic
   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      green_el_in  = green_el_ff;
      yellow_el_in = yellow_el_ff;
      leave_el_in  = leave_el_ff;
      walk_el_in   = walk_el_ff;
      walk_req_in  = walk_req_ff;
      train_in     = train_ff;
      maint_in     = maint_ff;
      parity_in    = parity_ff;
      light_in     = light_ff;
      walk_lamp_in = walk_lamp_ff;
      act          = GATE_KEEP;
      load_val     = gate_open_ff;
      adv          = 1'b0;

      tick_inc = tick_ff + 1'b1;
      // mod counter follows the 16-bit count, including its wrap to zero
      if (tick_inc == '0) begin
         blink_step = '0;
      end else if (blink_cnt_ff == BLINK_W'(BLINK_PERIOD - 1)) begin
         blink_step = '0;
      end else begin
         blink_step = blink_cnt_ff + 1'b1;
      end

      case (req_bus.cmd)
         CMD_TICK: begin
            tick_in = tick_inc;
            case (phase_ff)
               PH_MOVING: begin
                  if (tick_inc == traffic_ticks_ff) begin
                     green_el_in = 1'b1;
                     adv         = 1'b1;
                  end
               end
               PH_YELLOW: begin
                  if (tick_inc == yellow_ticks_ff) begin
                     yellow_el_in = 1'b1;
                     adv          = 1'b1;
                  end
               end
               PH_STOPPED: adv = 1'b1;
               PH_LEAVING: begin
                  if (tick_inc == walk_ticks_ff) begin
                     leave_el_in = 1'b1;
                     adv         = 1'b1;
                  end
               end
               PH_WALK: begin
                  if (tick_inc == walk_ticks_ff) begin
                     walk_el_in = 1'b1;
                     adv        = 1'b1;
                  end
               end
               PH_MAINT: begin
                  // gate follows the pot while the crossing is clear
                  if (!train_ff) act = GATE_POT;
                  if (blink_step == '0) begin
                     parity_in = !parity_ff;
                     light_in  = parity_in ? LAMP_BLUE : LAMP_OFF;
                  end
               end
               default: ;
            endcase
         end
         CMD_BUTTON: begin
            walk_req_in = 1'b1;
            if (phase_ff == PH_TRAIN || phase_ff == PH_MAINT) begin
               walk_lamp_in = 1'b1;
            end else begin
               adv = 1'b1;
            end
         end
         CMD_REMOTE: begin
            if ((req_bus.remote_code == RC_TRAIN_ARRIVE && !train_ff) ||
                (req_bus.remote_code == RC_TRAIN_LEAVE && train_ff)) begin
               if (phase_ff == PH_TRAIN) begin
                  train_in = 1'b0;
                  adv      = 1'b1;
               end else if (phase_ff == PH_MAINT) begin
                  // in maintenance a train only moves the gate
                  train_in = !train_ff;
                  act      = GATE_LOAD;
                  load_val = train_in ? gate_closed_ff : gate_open_ff;
               end else begin
                  train_in = 1'b1;
                  if (phase_ff == PH_STOPPED || phase_ff == PH_WALK) begin
                     phase_in = PH_TRAIN;
                     if (walk_req_ff) walk_lamp_in = 1'b1;
                     act      = GATE_LOAD;
                     load_val = gate_closed_ff;
                  end else if (phase_ff != PH_YELLOW) begin
                     phase_in    = PH_YELLOW;
                     light_in    = LAMP_YELLOW;
                     tick_in     = '0;
                     green_el_in = 1'b0;
                  end
               end
            end else if ((req_bus.remote_code == RC_MAINT_START && !maint_ff) ||
                         (req_bus.remote_code == RC_MAINT_END && maint_ff)) begin
               if (phase_ff == PH_MAINT) begin
                  maint_in = 1'b0;
                  adv      = 1'b1;
               end else if (phase_ff == PH_TRAIN) begin
                  maint_in = 1'b1;
                  phase_in = PH_MAINT;
               end else begin
                  maint_in = 1'b1;
                  if (phase_ff != PH_YELLOW) begin
                     phase_in    = PH_YELLOW;
                     light_in    = LAMP_YELLOW;
                     tick_in     = '0;
                     green_el_in = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase

      // phase advance, evaluated on the flags as the event left them
      if (adv) begin
         case (phase_in)
            PH_MOVING: begin
               if (green_el_in && walk_req_in) begin
                  phase_in    = PH_YELLOW;
                  light_in    = LAMP_YELLOW;
                  tick_in     = '0;
                  green_el_in = 1'b0;
               end
            end
            PH_YELLOW: begin
               if (yellow_el_in) begin
                  phase_in     = PH_STOPPED;
                  light_in     = LAMP_RED;
                  tick_in      = '0;
                  yellow_el_in = 1'b0;
               end
            end
            PH_STOPPED: begin
               if (maint_in) begin
                  phase_in = PH_MAINT;
                  if (train_in) begin
                     act      = GATE_LOAD;
                     load_val = gate_closed_ff;
                  end
               end else if (train_in) begin
                  phase_in = PH_TRAIN;
                  if (walk_req_in) walk_lamp_in = 1'b1;
                  act      = GATE_LOAD;
                  load_val = gate_closed_ff;
               end else if (walk_req_in) begin
                  phase_in     = PH_WALK;
                  walk_req_in  = 1'b0;
                  walk_lamp_in = 1'b1;
               end
               tick_in = '0;
            end
            PH_TRAIN: begin
               if (!train_in) begin
                  phase_in = PH_LEAVING;
                  tick_in  = '0;
               end
            end
            PH_LEAVING: begin
               if (leave_el_in) begin
                  phase_in     = PH_MOVING;
                  walk_lamp_in = 1'b0;
                  walk_req_in  = 1'b0;
                  act          = GATE_LOAD;
                  load_val     = gate_open_ff;
                  tick_in      = '0;
                  leave_el_in  = 1'b0;
                  light_in     = LAMP_GREEN;
               end
            end
            PH_MAINT: begin
               if (!maint_in) begin
                  if (train_in) begin
                     phase_in = PH_TRAIN;
                     if (walk_req_in) walk_lamp_in = 1'b1;
                     act      = GATE_LOAD;
                     load_val = gate_closed_ff;
                     light_in = LAMP_RED;
                  end else if (walk_req_in) begin
                     phase_in     = PH_WALK;
                     walk_req_in  = 1'b0;
                     walk_lamp_in = 1'b1;
                     light_in     = LAMP_RED;
                  end else begin
                     phase_in     = PH_MOVING;
                     walk_el_in   = 1'b0;
                     walk_lamp_in = 1'b0;
                     light_in     = LAMP_GREEN;
                     act          = GATE_LOAD;
                     load_val     = gate_open_ff;
                  end
                  tick_in = '0;
               end
            end
            PH_WALK: begin
               if (walk_el_in) begin
                  phase_in     = PH_MOVING;
                  tick_in      = '0;
                  walk_el_in   = 1'b0;
                  walk_lamp_in = 1'b0;
                  light_in     = LAMP_GREEN;
                  act          = GATE_LOAD;
                  load_val     = gate_open_ff;
               end
            end
            default: ;
         endcase
      end

      // keep the mod counter in step with whatever the count became
      if (tick_in == '0) begin
         blink_cnt_in = '0;
      end else if (req_bus.cmd == CMD_TICK) begin
         blink_cnt_in = blink_step;
      end else begin
         blink_cnt_in = blink_cnt_ff;
      end

      // duty span times sample; direction follows which duty is larger
      up   = gate_open_ff >= gate_closed_ff;
      diff = up ? (gate_open_ff - gate_closed_ff) : (gate_closed_ff - gate_open_ff);

      s1_in.light    = light_in;
      s1_in.walk     = walk_lamp_in;
      s1_in.phase    = phase_in;
      s1_in.act      = act;
      s1_in.load_val = load_val;
      s1_in.lo       = gate_closed_ff;
      s1_in.up       = up;
      s1_in.prod     = PROD_W'(diff) * PROD_W'(req_bus.pot_sample);
   end

   // ---------------------------------------------------------------- stage 2: divide by full scale
   // x / (2^P - 1) ~ (x + x>>P + x>>2P + ...) >> P, low by at most one, then one correction
   always_comb begin
      sum = '0;
      for (int k = 0; k < NTERMS; k++) begin
         sum = sum + SUM_W'(s1_ff.prod >> (k * POT_BITS));
      end
      q_est = QE_W'(sum >> POT_BITS);
      rem   = SUM_W'(s1_ff.prod) + SUM_W'(q_est) - (SUM_W'(q_est) << POT_BITS);
      if (rem >= SUM_W'(POT_FULL)) begin
         quot_full = q_est + 1'b1;
      end else begin
         quot_full = q_est;
      end
      quot = DUTY_W'(quot_full);

      case (s1_ff.act)
         GATE_KEEP: gate_in = gate_ff;
         GATE_LOAD: gate_in = s1_ff.load_val;
         GATE_POT:  gate_in = s1_ff.up ? (s1_ff.lo + quot) : (s1_ff.lo - quot);
         default:   gate_in = gate_ff;
      endcase
   end

   // ---------------------------------------------------------------- handshake next values
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s2_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------- state and pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MOVING;
         tick_ff      <= '0;
         blink_cnt_ff <= '0;
         green_el_ff  <= 1'b0;
         yellow_el_ff <= 1'b0;
         leave_el_ff  <= 1'b0;
         walk_el_ff   <= 1'b0;
         walk_req_ff  <= 1'b0;
         train_ff     <= 1'b0;
         maint_ff     <= 1'b0;
         parity_ff    <= 1'b0;
         light_ff     <= LAMP_GREEN;
         walk_lamp_ff <= 1'b0;
         gate_ff      <= GATE_OPEN_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            blink_cnt_ff <= blink_cnt_in;
            green_el_ff  <= green_el_in;
            yellow_el_ff <= yellow_el_in;
            leave_el_ff  <= leave_el_in;
            walk_el_ff   <= walk_el_in;
            walk_req_ff  <= walk_req_in;
            train_ff     <= train_in;
            maint_ff     <= maint_in;
            parity_ff    <= parity_in;
            light_ff     <= light_in;
            walk_lamp_ff <= walk_lamp_in;
         end
         if (s2_adv) begin
            gate_ff <= gate_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end

      // payload, no reset
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      if (s2_adv) begin
         rsp_light_ff <= s1_ff.light;
         rsp_walk_ff  <= s1_ff.walk;
         rsp_phase_ff <= s1_ff.phase;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.light_code = rsp_light_ff;
   assign rsp_bus.walk_lamp  = rsp_walk_ff;
   assign rsp_bus.gate_duty  = gate_ff;
   assign rsp_bus.phase      = rsp_phase_ff;

`ifndef SYNTHESIS
   // train phase is only held while a train is present
   a_train_phase_flag: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TRAIN |-> train_ff)
      else $error("train phase without a train present");

   // maintenance phase is only held while maintenance is active
   a_maint_phase_flag: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_MAINT |-> maint_ff)
      else $error("maintenance phase without maintenance active");

   // mod counter never leaves its range
   a_blink_range: assert property (@(posedge clock) disable iff (reset)
      blink_cnt_ff < BLINK_W'(BLINK_PERIOD))
      else $error("blink counter out of range");

   // a full pipeline with a stalled response refuses new requests
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request accepted into a full pipeline");

   // a stage 1 entry that cannot move on is still there next cycle
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_adv) |=> s1_valid_ff)
      else $error("stage 1 entry lost while stalled");
`endif

endmodule
